FILE: design/nearest_two_bone_search_core_assert.svh
// assertion macros for the nearest two bone search core
// expects clk_i and rst_ni in the scope of each use
`ifndef NEAREST_TWO_BONE_SEARCH_CORE_ASSERT_SVH
`define NEAREST_TWO_BONE_SEARCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define NTB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ntb assertion failed");
`define NTB_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ntb forbidden condition seen");
`else
`define NTB_ASSERT(label, prop)
`define NTB_ASSERT_NEVER(label, expr)
`endif
`endif

FILE: design/ntb_pkg.sv
// shared types and constants for the nearest two bone search core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ntb_pkg;

  localparam int unsigned NUM_BONES_DEF  = 21;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned IDX_BITS       = 5;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_e;

  // control tag that travels with one table entry down the distance pipe
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [IDX_BITS-1:0] idx;
  } tag_t;

endpackage

`default_nettype wire

FILE: design/ntb_sqdist.sv
// squared distance pipe: squares registered, sum out combinational
// depends on ntb_pkg
`timescale 1ns / 1ps
`default_nettype none

module ntb_sqdist #(
  parameter int unsigned CoordBits = ntb_pkg::COORD_BITS_DEF,
  localparam int unsigned DistBits = 2 * CoordBits + 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [3*CoordBits-1:0]   center_i,
  input  wire logic [3*CoordBits-1:0]   vertex_i,
  input  wire ntb_pkg::tag_t            tag_i,
  output ntb_pkg::tag_t                 tag_o,
  output logic [DistBits-1:0]           dist_o
);

  localparam int unsigned SqBits = 2 * CoordBits + 1;

  logic signed [CoordBits:0]     diff [3];
  logic signed [2*CoordBits+1:0] prod [3];
  logic [SqBits-1:0]             sq_d [3];
  logic [SqBits-1:0]             sq_q [3];
  ntb_pkg::tag_t                 tag_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({center_i[k*CoordBits+CoordBits-1], center_i[k*CoordBits +: CoordBits]})
              - $signed({vertex_i[k*CoordBits+CoordBits-1], vertex_i[k*CoordBits +: CoordBits]});
      prod[k] = diff[k] * diff[k];
      // a square is never negative, top bit is always zero
      sq_d[k] = prod[k][SqBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= sq_d[k];
    end
  end

  assign tag_o  = tag_q;
  assign dist_o = DistBits'(sq_q[0]) + DistBits'(sq_q[1]) + DistBits'(sq_q[2]);

endmodule

`default_nettype wire

FILE: design/nearest_two_bone_search_core.sv
// a vertex request gives its strobe once every table entry has passed the scan and the distance pipe
// busy_o holds off new requests until a scan is through; while idle, one center load per cycle
// the scan reads one table entry per cycle from the center memory, that read sets the rate
// reset: asynchronous active low, clears control only; the center table is undefined
// until loaded, and every entry must be loaded before a vertex is classified
// the receiver cannot stall, each result shows for one cycle on valid_o
`timescale 1ns / 1ps
`default_nettype none

module nearest_two_bone_search_core #(
  parameter int unsigned NUM_BONES  = ntb_pkg::NUM_BONES_DEF,
  parameter int unsigned COORD_BITS = ntb_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request side
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic                               cmd_i,
  input  wire logic [ntb_pkg::IDX_BITS-1:0]       bone_index_i,
  input  wire logic signed [COORD_BITS-1:0]       joint_x_i,
  input  wire logic signed [COORD_BITS-1:0]       joint_y_i,
  input  wire logic signed [COORD_BITS-1:0]       joint_z_i,
  input  wire logic signed [COORD_BITS-1:0]       end_x_i,
  input  wire logic signed [COORD_BITS-1:0]       end_y_i,
  input  wire logic signed [COORD_BITS-1:0]       end_z_i,
  input  wire logic                               use_midpoint_i,
  input  wire logic signed [COORD_BITS-1:0]       vertex_x_i,
  input  wire logic signed [COORD_BITS-1:0]       vertex_y_i,
  input  wire logic signed [COORD_BITS-1:0]       vertex_z_i,
  // result side
  output logic                                    valid_o,
  output logic [ntb_pkg::IDX_BITS-1:0]            closest_bone_o,
  output logic [ntb_pkg::IDX_BITS-1:0]            second_bone_o
);

  localparam int unsigned AddrBits = $clog2(NUM_BONES);
  localparam int unsigned IdxBits  = ntb_pkg::IDX_BITS;
  localparam int unsigned EntBits  = 3 * COORD_BITS;
  localparam int unsigned DistBits = 2 * COORD_BITS + 3;
  localparam logic [AddrBits-1:0] LastAddr = AddrBits'(NUM_BONES - 1);

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  logic req_accept;
  logic load_req;
  logic vertex_req;
  logic load_in_range;

  assign req_accept    = start_i && !busy_o;
  assign load_req      = req_accept && (ntb_pkg::cmd_e'(cmd_i) == ntb_pkg::CMD_LOAD);
  assign vertex_req    = req_accept && (ntb_pkg::cmd_e'(cmd_i) == ntb_pkg::CMD_VERTEX);
  // loads beyond the table are dropped
  assign load_in_range = ({1'b0, bone_index_i} < (IdxBits + 1)'(NUM_BONES));

  // ---------------------------------------------------------------------------
  // center computation for a load: midpoint rounds toward minus infinity
  // ---------------------------------------------------------------------------
  logic [EntBits-1:0] center_wr;

  function automatic logic [COORD_BITS-1:0] center_of(
    input logic signed [COORD_BITS-1:0] joint,
    input logic signed [COORD_BITS-1:0] tip,
    input logic                         mid
  );
    logic signed [COORD_BITS:0] sum;
    sum = {joint[COORD_BITS-1], joint} + {tip[COORD_BITS-1], tip};
    return mid ? sum[COORD_BITS:1] : tip;
  endfunction

  assign center_wr = {center_of(joint_z_i, end_z_i, use_midpoint_i),
                      center_of(joint_y_i, end_y_i, use_midpoint_i),
                      center_of(joint_x_i, end_x_i, use_midpoint_i)};

  // ---------------------------------------------------------------------------
  // center table: one write port for loads, one registered read port for the scan
  // loads and scans never overlap since busy_o blocks requests during a scan
  // ---------------------------------------------------------------------------
  logic [EntBits-1:0] center_mem [NUM_BONES];
  logic [EntBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (load_req && load_in_range) begin
      center_mem[bone_index_i[AddrBits-1:0]] <= center_wr;
    end
  end

  // ---------------------------------------------------------------------------
  // scan sequencer: walks the table addresses in order, one per cycle
  // ---------------------------------------------------------------------------
  logic                scan_q, scan_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [EntBits-1:0]  vertex_q;
  ntb_pkg::tag_t       rd_tag_q, rd_tag_d;

  always_comb begin
    scan_d   = scan_q;
    addr_d   = addr_q;
    rd_tag_d = '0;
    if (vertex_req) begin
      scan_d = 1'b1;
      addr_d = '0;
    end else if (scan_q) begin
      rd_tag_d.valid = 1'b1;
      rd_tag_d.last  = (addr_q == LastAddr);
      rd_tag_d.idx   = IdxBits'(addr_q);
      addr_d         = addr_q + 1'b1;
      if (addr_q == LastAddr) begin
        scan_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= 1'b0;
      addr_q   <= '0;
      rd_tag_q <= '0;
    end else begin
      scan_q   <= scan_d;
      addr_q   <= addr_d;
      rd_tag_q <= rd_tag_d;
    end
  end

  // registered table read and vertex capture
  always_ff @(posedge clk_i) begin
    if (scan_q) begin
      rd_data_q <= center_mem[addr_q];
    end
    if (vertex_req) begin
      vertex_q <= {vertex_z_i, vertex_y_i, vertex_x_i};
    end
  end

  // ---------------------------------------------------------------------------
  // squared distance pipe
  // ---------------------------------------------------------------------------
  ntb_pkg::tag_t       sq_tag;
  logic [DistBits-1:0] cur_dist;

  ntb_sqdist #(
    .CoordBits (COORD_BITS)
  ) u_sqdist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .center_i (rd_data_q),
    .vertex_i (vertex_q),
    .tag_i    (rd_tag_q),
    .tag_o    (sq_tag),
    .dist_o   (cur_dist)
  );

  // ---------------------------------------------------------------------------
  // running two minima; strict compares so the lower index wins a tie
  // ---------------------------------------------------------------------------
  logic [DistBits-1:0] best_q, best_d, next_q, next_d;
  logic [IdxBits-1:0]  fi_q, fi_d, si_q, si_d;
  logic                valid_q;
  logic [IdxBits-1:0]  closest_q, second_q;

  always_comb begin
    best_d = best_q;
    next_d = next_q;
    fi_d   = fi_q;
    si_d   = si_q;
    if (vertex_req) begin
      // all ones sits above any reachable squared distance
      best_d = '1;
      next_d = '1;
      fi_d   = '0;
      si_d   = '0;
    end else if (sq_tag.valid) begin
      if (cur_dist < best_q) begin
        next_d = best_q;
        si_d   = fi_q;
        best_d = cur_dist;
        fi_d   = sq_tag.idx;
      end else if (cur_dist < next_q) begin
        next_d = cur_dist;
        si_d   = sq_tag.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= sq_tag.valid && sq_tag.last;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    next_q <= next_d;
    fi_q   <= fi_d;
    si_q   <= si_d;
    if (sq_tag.valid && sq_tag.last) begin
      closest_q <= fi_d;
      second_q  <= si_d;
    end
  end

  // busy until the last entry has left the distance pipe
  assign busy_o         = scan_q || rd_tag_q.valid || sq_tag.valid;
  assign valid_o        = valid_q;
  assign closest_bone_o = closest_q;
  assign second_bone_o  = second_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "nearest_two_bone_search_core_assert.svh"

  `NTB_ASSERT(a_vertex_starts_scan, vertex_req |=> scan_q && (addr_q == '0))
  `NTB_ASSERT(a_last_gives_result, (sq_tag.valid && sq_tag.last) |=> valid_o)
  `NTB_ASSERT_NEVER(a_result_while_busy, valid_o && busy_o)
  `NTB_ASSERT(a_two_distinct_bones, valid_o |-> (closest_bone_o != second_bone_o))

endmodule

`default_nettype wire
